// ----- design/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    // Request kinds carried on the input channel. The unused code is a tick.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // Flags latched when a command is taken.
    typedef struct packed {
        logic start;
        logic nack;
        logic stop;
        logic read;
    } cmd_flags_t;

    localparam logic [7:0] DELAY_TICKS_RESET = 8'd3;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
    localparam int unsigned MSB_INDEX        = 7;

endpackage : i2cm_pkg

`default_nettype wire

// ----- design/i2c_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Byte-level I2C master sequencer for open-drain SCL and SDA lines.
// ----------------------------------------------------------------------------
// Every request on the input channel is either a tick, which carries the
// sampled SCL and SDA levels and advances the bus sequencer by one step, or a
// write or read byte command. The block returns exactly one result per
// request, giving the line drive, busy, done, received byte, acknowledge and
// rejected flags as they stand after that request. A request moves from the
// input register to the result register; the sequencer state is updated on
// that same edge, so the block sustains one request per clock cycle.
// The only thing that holds it back is a full result register that the
// consumer does not drain. The half-phase delay register is written through
// the configuration channel, which is always ready; it should be written only
// while no command is in progress. A delay of zero acts as one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    // Configuration write channel: half-phase delay in ticks.
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,

    // Request channel.
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] tx_byte,
    input  wire logic       start_cond,
    input  wire logic       stop_cond,
    input  wire logic       send_nack,
    input  wire logic       scl_level,
    input  wire logic       sda_level,

    // Result channel.
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_low,
    output logic            sda_low,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      rx_byte,
    output logic            ack_result,
    output logic            rejected
);

    // Sequencer phases. The D phases count delay ticks, the W phases hold
    // SCL released until the target lets it go high.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_RS_D1 = 5'd1,
        PH_RS_W  = 5'd2,
        PH_RS_D2 = 5'd3,
        PH_ST_D  = 5'd4,
        PH_WB_D1 = 5'd5,
        PH_WB_W  = 5'd6,
        PH_WB_D2 = 5'd7,
        PH_WB_D3 = 5'd8,
        PH_RB_D1 = 5'd9,
        PH_RB_W  = 5'd10,
        PH_RB_D2 = 5'd11,
        PH_RB_D3 = 5'd12,
        PH_SP_D1 = 5'd13,
        PH_SP_W  = 5'd14,
        PH_SP_D2 = 5'd15,
        PH_SP_D3 = 5'd16
    } phase_t;

    // Line action that opens a bit: the SDA drive and the delay phase.
    typedef struct packed {
        logic   sda_drv;
        phase_t ph;
    } bit_start_t;

    // Choose how the next bit starts: data bits first, then the acknowledge
    // slot, which runs the opposite direction of the data bits.
    function automatic bit_start_t begin_bit(input logic [3:0] cnt,
                                             input logic       msb,
                                             input cmd_flags_t fl);
        bit_start_t r;
        logic       as_write;
        logic       wbit;
        if (cnt < BITS_PER_BYTE)
        begin
            as_write = !fl.read;
            wbit     = msb;
        end
        else
        begin
            as_write = fl.read;
            wbit     = fl.nack;
        end
        if (as_write)
        begin
            r.sda_drv = !wbit;
            r.ph      = PH_WB_D1;
        end
        else
        begin
            r.sda_drv = 1'b0;
            r.ph      = PH_RB_D1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------------
    logic [7:0] delay_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_ticks_reg <= DELAY_TICKS_RESET;
        else if (cfg_valid && cfg_ready)
            delay_ticks_reg <= cfg_data;
    end

    // ------------------------------------------------------------------------
    // Input register. It advances into the sequencer whenever the result
    // register is free or is being emptied in the same cycle.
    // ------------------------------------------------------------------------
    logic       a_valid_reg;
    kind_t      a_kind_reg;
    logic [7:0] a_tx_byte_reg;
    logic       a_start_reg;
    logic       a_stop_reg;
    logic       a_nack_reg;
    logic       a_scl_reg;
    logic       a_sda_reg;
    logic       out_valid_reg;
    logic       a_advance;

    assign a_advance = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !a_valid_reg || a_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_kind_reg    <= kind_t'(kind);
            a_tx_byte_reg <= tx_byte;
            a_start_reg   <= start_cond;
            a_stop_reg    <= stop_cond;
            a_nack_reg    <= send_nack;
            a_scl_reg     <= scl_level;
            a_sda_reg     <= sda_level;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------------
    phase_t     phase_reg,       phase_next;
    logic [3:0] bit_count_reg,   bit_count_next;
    logic [7:0] shift_reg_reg,   shift_reg_next;
    logic [7:0] delay_count_reg, delay_count_next;
    logic       bus_started_reg, bus_started_next;
    cmd_flags_t cmd_flags_reg,   cmd_flags_next;
    logic       scl_drv_reg,     scl_drv_next;
    logic       sda_drv_reg,     sda_drv_next;
    logic       ack_reg_reg,     ack_reg_next;
    logic       sampled_reg,     sampled_next;
    logic       finished_next;
    logic       rejected_next;

    logic [7:0] delay_load;
    assign delay_load = (delay_ticks_reg == 8'd0) ? 8'd1 : delay_ticks_reg;

    always_comb
    begin
        bit_start_t bs;
        logic       is_cmd;
        logic       rd;
        logic       run_delay_end;
        logic       run_bit_done;

        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_reg_next   = shift_reg_reg;
        delay_count_next = delay_count_reg;
        bus_started_next = bus_started_reg;
        cmd_flags_next   = cmd_flags_reg;
        scl_drv_next     = scl_drv_reg;
        sda_drv_next     = sda_drv_reg;
        ack_reg_next     = ack_reg_reg;
        sampled_next     = sampled_reg;
        finished_next    = 1'b0;
        rejected_next    = 1'b0;
        run_delay_end    = 1'b0;
        run_bit_done     = 1'b0;
        bs               = '0;

        is_cmd = (a_kind_reg == KIND_WRITE) || (a_kind_reg == KIND_READ);
        rd     = (a_kind_reg == KIND_READ);

        if (is_cmd)
        begin
            if (phase_reg == PH_IDLE)
            begin
                cmd_flags_next.read  = rd;
                cmd_flags_next.stop  = a_stop_reg;
                cmd_flags_next.nack  = a_nack_reg;
                cmd_flags_next.start = !rd && a_start_reg;
                bit_count_next       = 4'd0;
                shift_reg_next       = rd ? 8'd0 : a_tx_byte_reg;
                if (cmd_flags_next.start)
                begin
                    // Repeated start drops SDA to released first; a fresh
                    // start pulls SDA low with SCL assumed high.
                    sda_drv_next     = !bus_started_reg;
                    phase_next       = bus_started_reg ? PH_RS_D1 : PH_ST_D;
                    delay_count_next = delay_load;
                end
                else
                begin
                    bs               = begin_bit(4'd0, shift_reg_next[MSB_INDEX],
                                                 cmd_flags_next);
                    sda_drv_next     = bs.sda_drv;
                    phase_next       = bs.ph;
                    delay_count_next = delay_load;
                end
            end
            else
            begin
                rejected_next = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_RS_W, PH_WB_W, PH_SP_W:
                begin
                    if (a_scl_reg)
                    begin
                        delay_count_next = delay_load;
                        case (phase_reg)
                            PH_RS_W: phase_next = PH_RS_D2;
                            PH_WB_W: phase_next = PH_WB_D2;
                            default: phase_next = PH_SP_D2;
                        endcase
                    end
                end
                PH_RB_W:
                begin
                    if (a_scl_reg)
                    begin
                        sampled_next     = a_sda_reg;
                        phase_next       = PH_RB_D2;
                        delay_count_next = delay_load;
                    end
                end
                default:
                begin
                    if (delay_count_reg > 8'd1)
                    begin
                        delay_count_next = delay_count_reg - 8'd1;
                    end
                    else
                    begin
                        delay_count_next = 8'd0;
                        run_delay_end    = 1'b1;
                    end
                end
            endcase
        end

        if (run_delay_end)
        begin
            case (phase_reg)
                PH_RS_D1, PH_WB_D1, PH_RB_D1, PH_SP_D1:
                begin
                    scl_drv_next = 1'b0;
                    case (phase_reg)
                        PH_RS_D1: phase_next = PH_RS_W;
                        PH_WB_D1: phase_next = PH_WB_W;
                        PH_RB_D1: phase_next = PH_RB_W;
                        default:  phase_next = PH_SP_W;
                    endcase
                end
                PH_RS_D2:
                begin
                    sda_drv_next     = 1'b1;
                    phase_next       = PH_ST_D;
                    delay_count_next = delay_load;
                end
                PH_ST_D:
                begin
                    scl_drv_next     = 1'b1;
                    bus_started_next = 1'b1;
                    bs               = begin_bit(bit_count_reg,
                                                 shift_reg_reg[MSB_INDEX],
                                                 cmd_flags_reg);
                    sda_drv_next     = bs.sda_drv;
                    phase_next       = bs.ph;
                    delay_count_next = delay_load;
                end
                PH_WB_D2, PH_RB_D2:
                begin
                    scl_drv_next     = 1'b1;
                    phase_next       = (phase_reg == PH_WB_D2) ? PH_WB_D3 : PH_RB_D3;
                    delay_count_next = delay_load;
                end
                PH_WB_D3:
                begin
                    sampled_next = 1'b0;
                    run_bit_done = 1'b1;
                end
                PH_RB_D3:
                begin
                    run_bit_done = 1'b1;
                end
                PH_SP_D2:
                begin
                    sda_drv_next     = 1'b0;
                    phase_next       = PH_SP_D3;
                    delay_count_next = delay_load;
                end
                PH_SP_D3:
                begin
                    bus_started_next = 1'b0;
                    phase_next       = PH_IDLE;
                    finished_next    = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (run_bit_done)
        begin
            if (bit_count_reg < BITS_PER_BYTE)
            begin
                shift_reg_next   = {shift_reg_reg[MSB_INDEX-1:0],
                                    cmd_flags_reg.read & sampled_next};
                bit_count_next   = bit_count_reg + 4'd1;
                bs               = begin_bit(bit_count_next,
                                             shift_reg_next[MSB_INDEX],
                                             cmd_flags_reg);
                sda_drv_next     = bs.sda_drv;
                phase_next       = bs.ph;
                delay_count_next = delay_load;
            end
            else
            begin
                if (!cmd_flags_reg.read)
                    ack_reg_next = sampled_next;
                if (cmd_flags_reg.stop)
                begin
                    sda_drv_next     = 1'b1;
                    phase_next       = PH_SP_D1;
                    delay_count_next = delay_load;
                end
                else
                begin
                    phase_next    = PH_IDLE;
                    finished_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= 4'd0;
            shift_reg_reg   <= 8'd0;
            delay_count_reg <= 8'd0;
            bus_started_reg <= 1'b0;
            cmd_flags_reg   <= '0;
            scl_drv_reg     <= 1'b0;
            sda_drv_reg     <= 1'b0;
            ack_reg_reg     <= 1'b0;
            sampled_reg     <= 1'b0;
        end
        else if (a_advance)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_reg_reg   <= shift_reg_next;
            delay_count_reg <= delay_count_next;
            bus_started_reg <= bus_started_next;
            cmd_flags_reg   <= cmd_flags_next;
            scl_drv_reg     <= scl_drv_next;
            sda_drv_reg     <= sda_drv_next;
            ack_reg_reg     <= ack_reg_next;
            sampled_reg     <= sampled_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result register. It holds the state as it stands after the request.
    // ------------------------------------------------------------------------
    logic       scl_low_reg;
    logic       sda_low_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [7:0] rx_byte_reg;
    logic       ack_out_reg;
    logic       rejected_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (a_advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            scl_low_reg  <= scl_drv_next;
            sda_low_reg  <= sda_drv_next;
            busy_reg     <= (phase_next != PH_IDLE);
            done_reg     <= finished_next;
            rx_byte_reg  <= (phase_next == PH_IDLE && cmd_flags_next.read) ?
                            shift_reg_next : 8'd0;
            ack_out_reg  <= ack_reg_next;
            rejected_reg <= rejected_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_low    = scl_low_reg;
    assign sda_low    = sda_low_reg;
    assign busy_res   = busy_reg;
    assign done_res   = done_reg;
    assign rx_byte    = rx_byte_reg;
    assign ack_result = ack_out_reg;
    assign rejected   = rejected_reg;

`ifndef SYNTHESIS
    // A finished command leaves the sequencer idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // A rejected command was refused because one was in progress.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> busy_res && !done_res)
        else $error("command rejected while idle");

    // No received byte is shown while a command runs.
    a_rx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && busy_res |-> rx_byte == 8'd0)
        else $error("received byte shown while busy");

    // The bit counter never passes the acknowledge slot.
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= BITS_PER_BYTE)
        else $error("bit counter out of range");

    // The delay counter is always spent when the sequencer goes idle.
    a_idle_delay: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> delay_count_reg == 8'd0)
        else $error("delay counter left running while idle");
`endif

endmodule : i2c_master_byte_engine

`default_nettype wire

// ----- tb/sv/i2c_master_byte_engine_tb.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Self-checking bench for the I2C master byte engine.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a driver that launches them on the falling
// clock edge, with random gaps. A monitor on the rising edge mirrors every
// accepted request into a cycle-accurate model of the byte sequencer and
// checks every returned status against the oldest predicted one. The run
// covers fresh and repeated starts, writes without a start, reads with ACK and
// NACK, stops, clock stretching, commands that arrive while busy, ticks while
// idle, the spare kind code and half-phase delays of 0, 1 and 2.
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int unsigned CLK_PERIOD  = 12;
    localparam int unsigned RESET_TICKS = 12;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    // A request passes the input register and then the result register; allow margin.
    localparam int unsigned SETTLE_CYCLES = 4;
    // How many requests the stimulus process keeps queued ahead of the driver.
    localparam int unsigned QUEUE_AHEAD = 8;

    // The fourth kind code is not named in the package; the block treats it
    // as a tick.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // One request on the input channel.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       start;
        logic       stop;
        logic       nack;
        logic       scl;
        logic       sda;
    } bus_req_t;

    // One status word on the result channel.
    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
        logic       refused;
    } bus_status_t;

    // Sequencer steps of the model. Each bit is a setup delay with SCL low,
    // a wait for SCL to be seen high, a high delay and a hold delay after
    // SCL is pulled low again. Start, repeated start and stop use the same
    // pattern on the other line.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RSTART_SETUP, ST_RSTART_WAIT, ST_RSTART_HIGH, ST_START_HOLD,
        ST_WBIT_SETUP, ST_WBIT_WAIT, ST_WBIT_HIGH, ST_WBIT_HOLD,
        ST_RBIT_SETUP, ST_RBIT_WAIT, ST_RBIT_HIGH, ST_RBIT_HOLD,
        ST_STOP_SETUP, ST_STOP_WAIT, ST_STOP_HIGH, ST_STOP_HOLD
    } seq_state_t;

    // ------------------------------------------------------------------------
    // Signals to and from the block. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data   = 8'd0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [1:0] kind       = 2'd0;
    logic [7:0] tx_byte    = 8'd0;
    logic       start_cond = 1'b0;
    logic       stop_cond  = 1'b0;
    logic       send_nack  = 1'b0;
    logic       scl_level  = 1'b0;
    logic       sda_level  = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_result;
    logic       rejected;

    i2c_master_byte_engine u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .tx_byte    (tx_byte),
        .start_cond (start_cond),
        .stop_cond  (stop_cond),
        .send_nack  (send_nack),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .scl_low    (scl_low),
        .sda_low    (sda_low),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .rx_byte    (rx_byte),
        .ack_result (ack_result),
        .rejected   (rejected)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    // Requests waiting to be sent. The head stays in the queue while the
    // driver presents it and is removed by the monitor when it is accepted,
    // so an empty queue means every request has reached the model.
    bus_req_t    request_q[$];
    // Status words the block still owes, oldest first.
    bus_status_t predicted_status_q[$];

    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned cfg_writes    = 0;
    // Requests that did work: commands taken while idle and ticks while busy.
    int unsigned active_items  = 0;
    logic        req_taken     = 1'b0;
    logic        send_idle_on  = 1'b0;
    logic        recv_stall_on = 1'b0;
    int unsigned send_gap      = 0;
    int unsigned recv_hold     = 0;

    // ------------------------------------------------------------------------
    // Model of the byte sequencer, advanced once per accepted request.
    // ------------------------------------------------------------------------
    logic [7:0]  half_delay  = DELAY_TICKS_RESET;
    seq_state_t  seq_state   = ST_IDLE;
    logic [7:0]  hp_left     = 8'd0;
    logic [3:0]  bit_idx     = 4'd0;
    logic [7:0]  shreg       = 8'd0;
    logic        bus_open    = 1'b0;
    cmd_flags_t  cur_cmd     = '0;
    logic        drive_scl   = 1'b0;
    logic        drive_sda   = 1'b0;
    logic        ack_bit     = 1'b0;
    logic        sampled_sda = 1'b0;
    logic        byte_done   = 1'b0;

    // Enter a delay step. A programmed delay of zero still lasts one tick.
    task automatic arm_delay(input seq_state_t next);
        seq_state = next;
        hp_left   = (half_delay == 8'd0) ? 8'd1 : half_delay;
    endtask

    // Put a bit on SDA that the master drives; a zero pulls the line low.
    task automatic drive_bit(input logic value);
        drive_sda = !value;
        arm_delay(ST_WBIT_SETUP);
    endtask

    // Release SDA so that the target can drive the bit.
    task automatic release_bit();
        drive_sda = 1'b0;
        arm_delay(ST_RBIT_SETUP);
    endtask

    // Eight data bits go out (write) or come in (read); the ninth bit goes
    // the other way and carries the acknowledge.
    task automatic next_bit();
        if (bit_idx < BITS_PER_BYTE)
        begin
            if (cur_cmd.read)
                release_bit();
            else
                drive_bit(shreg[MSB_INDEX]);
        end
        else if (cur_cmd.read)
            drive_bit(cur_cmd.nack);
        else
            release_bit();
    endtask

    task automatic close_bit();
        if (bit_idx < BITS_PER_BYTE)
        begin
            shreg   = {shreg[6:0], cur_cmd.read ? sampled_sda : 1'b0};
            bit_idx = bit_idx + 4'd1;
            next_bit();
        end
        else
        begin
            if (!cur_cmd.read)
                ack_bit = sampled_sda;
            if (cur_cmd.stop)
            begin
                // Stop: SDA low first, then SCL released, then SDA released.
                drive_sda = 1'b1;
                arm_delay(ST_STOP_SETUP);
            end
            else
            begin
                seq_state = ST_IDLE;
                byte_done = 1'b1;
            end
        end
    endtask

    // The line action that follows the last tick of a delay step.
    task automatic half_phase_over();
        case (seq_state)
            ST_RSTART_SETUP:
            begin
                drive_scl = 1'b0;
                seq_state = ST_RSTART_WAIT;
            end
            ST_RSTART_HIGH:
            begin
                drive_sda = 1'b1;
                arm_delay(ST_START_HOLD);
            end
            ST_START_HOLD:
            begin
                drive_scl = 1'b1;
                bus_open  = 1'b1;
                next_bit();
            end
            ST_WBIT_SETUP:
            begin
                drive_scl = 1'b0;
                seq_state = ST_WBIT_WAIT;
            end
            ST_WBIT_HIGH:
            begin
                drive_scl = 1'b1;
                arm_delay(ST_WBIT_HOLD);
            end
            ST_WBIT_HOLD:
            begin
                sampled_sda = 1'b0;
                close_bit();
            end
            ST_RBIT_SETUP:
            begin
                drive_scl = 1'b0;
                seq_state = ST_RBIT_WAIT;
            end
            ST_RBIT_HIGH:
            begin
                drive_scl = 1'b1;
                arm_delay(ST_RBIT_HOLD);
            end
            ST_RBIT_HOLD:
                close_bit();
            ST_STOP_SETUP:
            begin
                drive_scl = 1'b0;
                seq_state = ST_STOP_WAIT;
            end
            ST_STOP_HIGH:
            begin
                drive_sda = 1'b0;
                arm_delay(ST_STOP_HOLD);
            end
            ST_STOP_HOLD:
            begin
                bus_open  = 1'b0;
                seq_state = ST_IDLE;
                byte_done = 1'b1;
            end
            default:
                seq_state = ST_IDLE;
        endcase
    endtask

    // Apply one accepted request and queue the status word it must produce.
    task automatic step_sequencer(input bus_req_t r);
        bus_status_t st;
        logic        refused;
        refused   = 1'b0;
        byte_done = 1'b0;
        if (r.kind == KIND_WRITE || r.kind == KIND_READ)
        begin
            if (seq_state != ST_IDLE)
                refused = 1'b1;
            else
            begin
                active_items++;
                cur_cmd.read  = (r.kind == KIND_READ);
                cur_cmd.stop  = r.stop;
                cur_cmd.nack  = r.nack;
                cur_cmd.start = !cur_cmd.read && r.start;
                bit_idx       = 4'd0;
                shreg         = cur_cmd.read ? 8'h00 : r.tx_byte;
                if (cur_cmd.start)
                begin
                    // On a started bus SDA is released first for a repeated
                    // start; otherwise SCL is taken to be high already.
                    if (bus_open)
                    begin
                        drive_sda = 1'b0;
                        arm_delay(ST_RSTART_SETUP);
                    end
                    else
                    begin
                        drive_sda = 1'b1;
                        arm_delay(ST_START_HOLD);
                    end
                end
                else
                    next_bit();
            end
        end
        else if (seq_state != ST_IDLE)
        begin
            // A tick, or the spare kind code, while a command is running.
            active_items++;
            case (seq_state)
                ST_RSTART_WAIT:
                    if (r.scl)
                        arm_delay(ST_RSTART_HIGH);
                ST_WBIT_WAIT:
                    if (r.scl)
                        arm_delay(ST_WBIT_HIGH);
                ST_RBIT_WAIT:
                    if (r.scl)
                    begin
                        sampled_sda = r.sda;
                        arm_delay(ST_RBIT_HIGH);
                    end
                ST_STOP_WAIT:
                    if (r.scl)
                        arm_delay(ST_STOP_HIGH);
                default:
                    if (hp_left > 8'd1)
                        hp_left = hp_left - 8'd1;
                    else
                    begin
                        hp_left = 8'd0;
                        half_phase_over();
                    end
            endcase
        end

        st.scl_low = drive_scl;
        st.sda_low = drive_sda;
        st.busy    = (seq_state != ST_IDLE);
        st.done    = byte_done;
        st.rx      = (seq_state == ST_IDLE && cur_cmd.read) ? shreg : 8'h00;
        st.ack     = ack_bit;
        st.refused = refused;
        predicted_status_q.push_back(st);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    // Mostly ticks with SCL seen high, so that stretched clocks stay short,
    // a few spare-kind ticks and a few commands. Commands land on a busy
    // engine now and then and must be refused.
    function automatic bus_req_t random_request();
        bus_req_t    r;
        int unsigned pick;
        r.tx_byte = 8'($urandom_range(0, 255));
        r.start   = ($urandom_range(0, 99) < 60);
        r.stop    = ($urandom_range(0, 99) < 35);
        r.nack    = 1'($urandom_range(0, 1));
        r.scl     = ($urandom_range(0, 99) < 75);
        r.sda     = 1'($urandom_range(0, 1));
        pick      = $urandom_range(0, 99);
        if (pick < 3)
            r.kind = KIND_WRITE;
        else if (pick < 6)
            r.kind = KIND_READ;
        else if (pick < 10)
            r.kind = KIND_SPARE;
        else
            r.kind = KIND_TICK;
        return r;
    endfunction

    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_pause();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return 0;
        else if (pick < 96)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic push_command(input logic [1:0] op, input logic [7:0] data,
                                input logic start, input logic stop, input logic nack);
        bus_req_t r;
        r         = random_request();
        r.kind    = op;
        r.tx_byte = data;
        r.start   = start;
        r.stop    = stop;
        r.nack    = nack;
        request_q.push_back(r);
    endtask

    // Feed ticks until the engine is idle and every request has been taken,
    // then wait for all owed status words and let the pipeline empty. The
    // sender is paused here until nothing more is expected.
    task automatic settle_bus();
        bus_req_t r;
        while (request_q.size() != 0 || seq_state != ST_IDLE)
        begin
            if (seq_state != ST_IDLE && request_q.size() < QUEUE_AHEAD)
            begin
                r      = random_request();
                r.kind = KIND_TICK;
                request_q.push_back(r);
            end
            else
                @(negedge clk);
        end
        while (predicted_status_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the half-phase delay; called at a falling edge with the engine idle.
    task automatic write_delay(input logic [7:0] value);
        int unsigned seen;
        seen      = cfg_writes;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        while (cfg_writes == seen)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random phase: new delay, idling modes, then random requests until
    // the engine has done the given amount of work.
    task automatic run_phase(input logic [7:0] value, input int unsigned work,
                             input logic idle_on, input logic stall_on);
        int unsigned goal;
        settle_bus();
        write_delay(value);
        send_idle_on  = idle_on;
        recv_stall_on = stall_on;
        goal          = active_items + work;
        while (active_items < goal)
        begin
            if (request_q.size() >= QUEUE_AHEAD)
                @(negedge clk);
            else
            begin
                request_q.push_back(random_request());
                // Once in a while hold the sender back until the block has
                // returned everything, wherever the engine happens to be.
                if ($urandom_range(0, 199) == 0)
                begin
                    while (request_q.size() != 0 || predicted_status_q.size() != 0)
                        @(negedge clk);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the head of the request queue on the falling edge and
    // holds it until the monitor has seen it accepted.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !req_taken)
            begin
                // Still waiting for the block to take the current request.
            end
            else if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (request_q.size() != 0)
            begin
                kind       <= request_q[0].kind;
                tx_byte    <= request_q[0].tx_byte;
                start_cond <= request_q[0].start;
                stop_cond  <= request_q[0].stop;
                send_nack  <= request_q[0].nack;
                scl_level  <= request_q[0].scl;
                sda_level  <= request_q[0].sda;
                in_valid   <= 1'b1;
                send_gap   = send_idle_on ? pick_pause() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side back-pressure, also on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n || !recv_stall_on)
            out_ready <= 1'b1;
        else if (recv_hold != 0)
        begin
            recv_hold--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_hold = pick_pause();
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples both handshakes on the rising edge, advances the model
    // on every accepted request and checks every returned status word.
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        bus_req_t    seen_req;
        bus_status_t want;
        req_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            cycle_count++;
            if (cfg_valid && cfg_ready)
            begin
                half_delay = cfg_data;
                cfg_writes++;
            end
            if (in_valid && in_ready)
            begin
                seen_req.kind    = kind;
                seen_req.tx_byte = tx_byte;
                seen_req.start   = start_cond;
                seen_req.stop    = stop_cond;
                seen_req.nack    = send_nack;
                seen_req.scl     = scl_level;
                seen_req.sda     = sda_level;
                step_sequencer(seen_req);
                void'(request_q.pop_front());
            end
            if (out_valid && out_ready)
            begin
                if (predicted_status_q.size() == 0)
                begin
                    $error("status word returned with none outstanding");
                    fail_count++;
                end
                else
                begin
                    want = predicted_status_q.pop_front();
                    check_field("scl_low", want.scl_low, scl_low);
                    check_field("sda_low", want.sda_low, sda_low);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("done_res", want.done, done_res);
                    check_field("rx_byte", want.rx, rx_byte);
                    check_field("ack_result", want.ack, ack_result);
                    check_field("rejected", want.refused, rejected);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        bus_req_t r;
        repeat (RESET_TICKS) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the shortest delay, with both sides idling.
        write_delay(8'd1);
        send_idle_on  = 1'b1;
        recv_stall_on = 1'b1;
        // A tick and a spare-kind request on an idle engine do nothing.
        r      = random_request();
        r.kind = KIND_TICK;
        request_q.push_back(r);
        r.kind = KIND_SPARE;
        request_q.push_back(r);
        // Start on a free bus with all ones, then a repeated start with all
        // zeros on the bus that is still held.
        push_command(KIND_WRITE, 8'hFF, 1'b1, 1'b0, 1'b0);
        settle_bus();
        push_command(KIND_WRITE, 8'h00, 1'b1, 1'b0, 1'b1);
        settle_bus();
        // Write without a start, ending with a stop; the read right behind
        // it finds the engine busy and must be refused.
        push_command(KIND_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0);
        push_command(KIND_READ, 8'h5A, 1'b1, 1'b0, 1'b0);
        settle_bus();
        // Reads never send a start, even when asked; one ACK, one NACK+stop.
        push_command(KIND_READ, 8'hFF, 1'b1, 1'b0, 1'b0);
        settle_bus();
        push_command(KIND_READ, 8'h00, 1'b0, 1'b1, 1'b1);
        settle_bus();
        push_command(KIND_WRITE, 8'h80, 1'b1, 1'b1, 1'b0);
        settle_bus();

        // Random phases. A delay of zero must behave as one tick.
        run_phase(8'd0, 40, 1'b1, 1'b1);
        run_phase(8'd2, 30, 1'b0, 1'b1);

        settle_bus();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
